[src/mlh_pkg.sv]
// ----------------------------------------------------------------------------
// mlh_pkg
// shared types and constants of the case-folding murmur2 hash unit
// ----------------------------------------------------------------------------
package mlh_pkg;

    localparam int LENGTH_BITS = 16;

    localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
    localparam int          MIX_SHIFT  = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET = 32'h31415926;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] message_length;
    } in_item_t;

    typedef struct packed {
        logic [31:0] hash_value;
        logic        length_mismatch;
    } out_item_t;

    // one hash operation handed from front to back
    typedef struct packed {
        logic        start;
        logic        mix;
        logic        fin;
        logic        has_tail;
        logic        mismatch;
        logic [31:0] start_val;
        logic [31:0] data;
    } op_t;

endpackage

[src/murmur2_lowercase_hash_unit.sv]
// ----------------------------------------------------------------------------
// murmur2_lowercase_hash_unit
// case-folding 32-bit murmur2 hash over a byte stream, one message at a time
// ----------------------------------------------------------------------------
// throughput: one byte per cycle within a message while the op queue has room;
//   the back end runs each full word through MIX1-MIX3 and each finish
//   through TAIL-FIN2 on its shared 32x32 multiplier, so short messages
//   fill the 4-entry op queue, and a last byte's result waits behind any
//   backlog there as well as for a free result slot in FIN2
// reset: seed returns to 0x31415926, message state and queues clear at once
module murmur2_lowercase_hash_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mlh_pkg::in_item_t   in_item,
    output logic                empty,
    input  logic                pop,
    output mlh_pkg::out_item_t  result,
    input  logic                hash_seed_we,
    input  logic [31:0]         hash_seed_wdata
);
    import mlh_pkg::*;

    logic op_push;
    logic op_full;
    op_t  op_word;
    logic q_pop;
    logic q_empty;
    op_t  q_head;

    mlh_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .in_item         (in_item),
        .hash_seed_we    (hash_seed_we),
        .hash_seed_wdata (hash_seed_wdata),
        .op_push         (op_push),
        .op_word         (op_word),
        .op_full         (op_full)
    );

    mlh_op_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (op_push),
        .op_in  (op_word),
        .full   (op_full),
        .pop    (q_pop),
        .op_out (q_head),
        .empty  (q_empty)
    );

    mlh_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

[src/mlh_front.sv]
// ----------------------------------------------------------------------------
// mlh_front
// takes bytes, folds case, packs words, tracks length, issues hash operations
// ----------------------------------------------------------------------------
module mlh_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  mlh_pkg::in_item_t in_item,
    input  logic              hash_seed_we,
    input  logic [31:0]       hash_seed_wdata,
    output logic              op_push,
    output mlh_pkg::op_t      op_word,
    input  logic              op_full
);
    import mlh_pkg::*;

    logic [31:0]            seed_reg;
    logic [23:0]            pend_reg,  pend_next;
    logic [1:0]             lane_reg,  lane_next;
    logic [LENGTH_BITS-1:0] cnt_reg,   cnt_next;
    logic [LENGTH_BITS-1:0] decl_reg,  decl_next;
    logic                   over_reg,  over_next;

    logic                   accept;
    logic [7:0]             b;
    logic [LENGTH_BITS-1:0] len;
    logic                   skip;
    logic [23:0]            pend_b;
    logic [1:0]             lane_b;
    logic [LENGTH_BITS-1:0] cnt_b;
    logic                   over_b;
    logic                   mix;

    assign full   = op_full;
    assign accept = push && !op_full;
    assign len    = LENGTH_BITS'(in_item.message_length);

    // A-Z folded to a-z
    always_comb
    begin
        b = in_item.data_byte;
        if (in_item.data_byte >= 8'h41 && in_item.data_byte <= 8'h5a)
            b = in_item.data_byte + 8'd32;
    end

    always_comb
    begin
        pend_b = in_item.first_byte ? 24'd0 : pend_reg;
        lane_b = in_item.first_byte ? 2'd0 : lane_reg;
        cnt_b  = in_item.first_byte ? '0 : cnt_reg;
        over_b = in_item.first_byte ? 1'b0 : over_reg;
        decl_next = in_item.first_byte ? len : decl_reg;
        skip   = in_item.first_byte && (len == '0);

        pend_next = pend_b;
        lane_next = lane_b;
        cnt_next  = cnt_b;
        over_next = over_b;
        mix       = 1'b0;
        op_word.data = {8'd0, pend_b};

        if (!skip)
        begin
            if (lane_b == 2'd3)
            begin
                mix          = 1'b1;
                op_word.data = {b, pend_b};
                pend_next    = 24'd0;
                lane_next    = 2'd0;
            end
            else
            begin
                case (lane_b)
                    2'd0:    pend_next[7:0]   = b;
                    2'd1:    pend_next[15:8]  = b;
                    2'd2:    pend_next[23:16] = b;
                    default: pend_next        = pend_b;
                endcase
                lane_next = lane_b + 2'd1;
            end
            if (cnt_b == {LENGTH_BITS{1'b1}})
                over_next = 1'b1;
            else
                cnt_next = cnt_b + 1'b1;
        end

        if (!mix)
            op_word.data = {8'd0, pend_next};
        op_word.start     = in_item.first_byte;
        op_word.mix       = mix;
        op_word.fin       = in_item.last_byte;
        op_word.has_tail  = (lane_next != 2'd0);
        op_word.mismatch  = over_next || (cnt_next != decl_next);
        op_word.start_val = seed_reg ^ 32'(len);

        // message state returns to reset after the last byte
        if (in_item.last_byte)
        begin
            pend_next = 24'd0;
            lane_next = 2'd0;
            cnt_next  = '0;
            over_next = 1'b0;
            decl_next = '0;
        end
    end

    assign op_push = accept && (in_item.first_byte || mix || in_item.last_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
            pend_reg <= 24'd0;
            lane_reg <= 2'd0;
            cnt_reg  <= '0;
            decl_reg <= '0;
            over_reg <= 1'b0;
        end
        else
        begin
            if (hash_seed_we)
                seed_reg <= hash_seed_wdata;
            if (accept)
            begin
                pend_reg <= pend_next;
                lane_reg <= lane_next;
                cnt_reg  <= cnt_next;
                decl_reg <= decl_next;
                over_reg <= over_next;
            end
        end
    end

endmodule

[src/mlh_op_queue.sv]
// ----------------------------------------------------------------------------
// mlh_op_queue
// short fifo of hash operations between front and back
// ----------------------------------------------------------------------------
module mlh_op_queue
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  mlh_pkg::op_t op_in,
    output logic         full,
    input  logic         pop,
    output mlh_pkg::op_t op_out,
    output logic         empty
);
    import mlh_pkg::*;

    op_t                ent_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0] cnt_reg,    cnt_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (cnt_reg == OQ_CNT_W'(OQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign op_out  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_ptr_reg] <= op_in;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("op queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("op queue popped while empty");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("op queue count did not grow on push");

endmodule

[src/mlh_back.sv]
// ----------------------------------------------------------------------------
// mlh_back
// runs hash operations through one shared multiplier and holds the result
// ----------------------------------------------------------------------------
module mlh_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  mlh_pkg::op_t        q_head,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output mlh_pkg::out_item_t  result
);
    import mlh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MIX1 = 3'd1;
    localparam logic [2:0] S_MIX2 = 3'd2;
    localparam logic [2:0] S_MIX3 = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;
    localparam logic [2:0] S_FIN1 = 3'd5;
    localparam logic [2:0] S_FIN2 = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [31:0] h_reg,     h_next;
    logic [31:0] k_reg,     k_next;
    op_t         op_reg,    op_next;
    out_item_t   res_reg,   res_next;
    logic        ov_reg,    ov_next;
    logic [31:0] mul_in;
    logic [31:0] mul_out;
    logic        slot_free;

    assign empty     = !ov_reg;
    assign result    = res_reg;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign slot_free = !ov_reg || pop;

    always_comb
    begin
        case (state_reg)
            S_MIX1:  mul_in = op_reg.data;
            S_MIX2:  mul_in = k_reg ^ (k_reg >> MIX_SHIFT);
            S_MIX3:  mul_in = h_reg;
            S_TAIL:  mul_in = h_reg ^ op_reg.data;
            S_FIN1:  mul_in = h_reg ^ (h_reg >> FIN_SHIFT_A);
            default: mul_in = h_reg;
        endcase
        mul_out = mul_in * MIX_MUL;
    end

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && !pop;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    op_next = q_head;
                    if (q_head.start)
                        h_next = q_head.start_val;
                    if (q_head.mix)
                        state_next = S_MIX1;
                    else if (q_head.fin)
                        state_next = S_TAIL;
                end
            end
            S_MIX1:
            begin
                k_next     = mul_out;
                state_next = S_MIX2;
            end
            S_MIX2:
            begin
                k_next     = mul_out;
                state_next = S_MIX3;
            end
            S_MIX3:
            begin
                h_next     = mul_out ^ k_reg;
                state_next = op_reg.fin ? S_TAIL : S_IDLE;
            end
            S_TAIL:
            begin
                if (op_reg.has_tail)
                    h_next = mul_out;
                state_next = S_FIN1;
            end
            S_FIN1:
            begin
                h_next     = mul_out;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                if (slot_free)
                begin
                    res_next.hash_value      = h_reg ^ (h_reg >> FIN_SHIFT_B);
                    res_next.length_mismatch = op_reg.mismatch;
                    ov_next                  = 1'b1;
                    h_next                   = 32'd0;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            h_reg     <= 32'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        op_reg  <= op_next;
        res_reg <= res_next;
    end

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN2 && slot_free) |=> (h_reg == 32'd0 && ov_reg))
        else $error("finish did not clear hash or post result");

    a_mix_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX1) |=> (state_reg == S_MIX2) ##1 (state_reg == S_MIX3))
        else $error("word mix sequence broken");

    a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN2 && !slot_free) |=> (state_reg == S_FIN2 && $stable(h_reg)))
        else $error("finish left while result slot busy");

endmodule

[test/mlh_checker.sv]
// ----------------------------------------------------------------------------
// mlh_checker
// watches both queues of the hash unit, predicts each finished hash and
// compares it with what the unit hands out
// ----------------------------------------------------------------------------
module mlh_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  mlh_pkg::in_item_t  in_item,
    input  logic               empty,
    input  logic               pop,
    input  mlh_pkg::out_item_t result,
    input  logic               hash_seed_we,
    input  logic [31:0]        hash_seed_wdata,
    output int unsigned        error_count,
    output int unsigned        outstanding,
    output int unsigned        hashes_checked,
    output int unsigned        mismatches_flagged
);
    timeunit 1ns;
    timeprecision 1ps;
    import mlh_pkg::*;

    logic [31:0] seed_copy = SEED_RESET;
    logic [31:0] run_hash;
    logic [23:0] pend_bytes;
    logic [1:0]  lane;
    logic [15:0] byte_cnt;
    logic [15:0] decl_len;
    logic        cnt_over;

    out_item_t   hash_expected_q [$];

    initial
    begin
        error_count        = 0;
        outstanding        = 0;
        hashes_checked     = 0;
        mismatches_flagged = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        $display("%0t checker: %s: expected %h got %h", $time, what, want, got);
    endtask

    task automatic clear_message_state();
        run_hash   = '0;
        pend_bytes = '0;
        lane       = '0;
        byte_cnt   = '0;
        decl_len   = '0;
        cnt_over   = 1'b0;
    endtask

    task automatic track_hash_item(input in_item_t it);
        logic [7:0]  b;
        logic [31:0] k;
        logic [31:0] h;
        out_item_t   want;
        b = it.data_byte;
        if (b >= 8'h41 && b <= 8'h5a)
            b = b + 8'h20;
        if (it.first_byte)
        begin
            clear_message_state();
            decl_len = it.message_length;
            run_hash = seed_copy ^ {16'h0, it.message_length};
        end
        // the opening word of an empty message carries no byte
        if (!(it.first_byte && it.message_length == '0))
        begin
            if (lane == 2'd3)
            begin
                k = {b, pend_bytes};
                k = k * MIX_MUL;
                k = k ^ (k >> MIX_SHIFT);
                k = k * MIX_MUL;
                run_hash   = (run_hash * MIX_MUL) ^ k;
                pend_bytes = '0;
                lane       = '0;
            end
            else
            begin
                pend_bytes = pend_bytes | ({16'h0, b} << (8 * lane));
                lane       = lane + 2'd1;
            end
            if (byte_cnt == '1)
                cnt_over = 1'b1;
            else
                byte_cnt = byte_cnt + 16'd1;
        end
        if (it.last_byte)
        begin
            h = run_hash;
            if (lane != 2'd0)
                h = (h ^ {8'h0, pend_bytes}) * MIX_MUL;
            h = h ^ (h >> FIN_SHIFT_A);
            h = h * MIX_MUL;
            h = h ^ (h >> FIN_SHIFT_B);
            want.hash_value      = h;
            want.length_mismatch = cnt_over || (byte_cnt != decl_len);
            hash_expected_q.push_back(want);
            clear_message_state();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            seed_copy = SEED_RESET;
            clear_message_state();
            hash_expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // results leave only after their last byte has passed the op queue and
            // the finish states, so checking them before taking a new word is safe
            if (pop && !empty)
            begin
                if (hash_expected_q.size() == 0)
                    report_mismatch("result with no hash pending", '0, result.hash_value);
                else
                begin
                    want = hash_expected_q.pop_front();
                    hashes_checked++;
                    if (want.length_mismatch)
                        mismatches_flagged++;
                    if (result.hash_value !== want.hash_value)
                        report_mismatch("hash_value", want.hash_value, result.hash_value);
                    if (result.length_mismatch !== want.length_mismatch)
                        report_mismatch("length_mismatch", {31'h0, want.length_mismatch},
                                        {31'h0, result.length_mismatch});
                end
            end
            if (push && !full)
                track_hash_item(in_item);
            if (hash_seed_we)
                seed_copy = hash_seed_wdata;
            outstanding <= hash_expected_q.size();
        end
    end

endmodule

[test/murmur2_lowercase_hash_unit_tb.sv]
// ----------------------------------------------------------------------------
// murmur2_lowercase_hash_unit_tb
// streams directed and random messages into the hash unit under random
// idling on both queues, across several seeds, and reports the verdict
// ----------------------------------------------------------------------------
module murmur2_lowercase_hash_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlh_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 2000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    in_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   result;
    logic        hash_seed_we = 1'b0;
    logic [31:0] hash_seed_wdata = '0;

    int unsigned error_count;
    int unsigned outstanding;
    int unsigned hashes_checked;
    int unsigned mismatches_flagged;

    int          items_sent = 0;
    int          cycles = 0;
    int          rx_hold = 0;
    bit          quiet_tx = 1'b0;
    bit          quiet_rx = 1'b0;
    logic [31:0] phase_seeds [4];

    murmur2_lowercase_hash_unit u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .in_item         (in_item),
        .empty           (empty),
        .pop             (pop),
        .result          (result),
        .hash_seed_we    (hash_seed_we),
        .hash_seed_wdata (hash_seed_wdata)
    );

    mlh_checker u_check
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .in_item            (in_item),
        .empty              (empty),
        .pop                (pop),
        .result             (result),
        .hash_seed_we       (hash_seed_we),
        .hash_seed_wdata    (hash_seed_wdata),
        .error_count        (error_count),
        .outstanding        (outstanding),
        .hashes_checked     (hashes_checked),
        .mismatches_flagged (mismatches_flagged)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: pop with random stalls
    always @(posedge clk)
    begin
        int g;
        if ($urandom_range(0, 499) == 0)
            quiet_rx = !quiet_rx;
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            pop <= 1'b0;
        end
        else if (pop && !empty)
        begin
            g = pick_gap(quiet_rx);
            if (g > 0)
            begin
                rx_hold = g - 1;
                pop <= 1'b0;
            end
        end
        else if (!pop)
            pop <= 1'b1;
    end

    task automatic send_item(input logic [7:0] b, input logic f, input logic l,
                             input logic [15:0] len);
        int gap;
        gap = pick_gap(quiet_tx);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        in_item <= '{data_byte: b, first_byte: f, last_byte: l, message_length: len};
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_message(input logic [15:0] decl, input int n_items, input bit close);
        logic [7:0] b;
        int         r;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                b = 8'($urandom_range(8'h41, 8'h5a));
            else if (r < 6)
                b = 8'($urandom_range(8'h61, 8'h7a));
            else
                b = 8'($urandom);
            send_item(b, i == 0, close && (i == n_items - 1),
                      (i == 0) ? decl : 16'($urandom));
        end
    endtask

    task automatic run_random_phase(input int goal);
        int start;
        int r;
        int len;
        start = items_sent;
        while (items_sent - start < goal)
        begin
            if ($urandom_range(0, 15) == 0)
                quiet_tx = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    len = 0;
                else if (r < 80)
                    len = $urandom_range(1, 8);
                else
                    len = $urandom_range(9, 40);
                send_message(16'(len), (len == 0) ? 1 : len, 1'b1);
            end
            else if (r < 85)
            begin
                len = $urandom_range(1, 20);
                if ($urandom_range(0, 1))
                    send_message(16'($urandom), len, 1'b1);
                else
                    send_message(16'(len + $urandom_range(1, 3)), len, 1'b1);
            end
            else if (r < 95)
                send_item(8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
            else
                // opened and abandoned; the next first word restarts
                send_message(16'($urandom_range(1, 12)), $urandom_range(1, 6), 1'b0);
        end
        send_message(16'd5, 5, 1'b1);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        hash_seed_we    <= 1'b1;
        hash_seed_wdata <= v;
        @(posedge clk);
        hash_seed_we    <= 1'b0;
    endtask

    initial
    begin
        phase_seeds[0] = 32'h0000_0000;
        phase_seeds[1] = 32'hffff_ffff;
        phase_seeds[2] = $urandom;
        phase_seeds[3] = $urandom;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, its byte is dropped
        send_item(8'h41, 1'b1, 1'b1, 16'h0000);
        // one upper-case byte, first and last on one word
        send_item(8'h41, 1'b1, 1'b1, 16'h0001);
        // exactly one full word, the last byte completes it
        send_item(8'h41, 1'b1, 1'b0, 16'h0004);
        send_item(8'h5a, 1'b0, 1'b0, 16'hffff);
        send_item(8'h61, 1'b0, 1'b0, 16'h0000);
        send_item(8'h7a, 1'b0, 1'b1, 16'hffff);
        // characters just outside the upper- and lower-case ranges, one tail byte
        send_item(8'h40, 1'b1, 1'b0, 16'h0005);
        send_item(8'h5b, 1'b0, 1'b0, 16'h0000);
        send_item(8'h60, 1'b0, 1'b0, 16'hffff);
        send_item(8'h7b, 1'b0, 1'b0, 16'h0000);
        send_item(8'hff, 1'b0, 1'b1, 16'hffff);
        // largest declared length, short message
        send_item(8'h00, 1'b1, 1'b0, 16'hffff);
        send_item(8'h5a, 1'b0, 1'b0, 16'h0000);
        send_item(8'h80, 1'b0, 1'b1, 16'hffff);
        // last without first after a finished message
        send_item(8'h61, 1'b0, 1'b1, 16'h1234);
        // zero length opened without last, bytes follow anyway
        send_item(8'h55, 1'b1, 1'b0, 16'h0000);
        send_item(8'h41, 1'b0, 1'b0, 16'hffff);
        send_item(8'h42, 1'b0, 1'b1, 16'h0000);
        // restart in the middle of a message
        send_item(8'h78, 1'b1, 1'b0, 16'h0003);
        send_item(8'h79, 1'b0, 1'b0, 16'h0000);
        send_item(8'h50, 1'b1, 1'b0, 16'h0002);
        send_item(8'h51, 1'b0, 1'b1, 16'hffff);
        // more bytes than declared
        send_item(8'h7f, 1'b1, 1'b0, 16'h0002);
        send_item(8'h01, 1'b0, 1'b0, 16'h0000);
        send_item(8'hfe, 1'b0, 1'b1, 16'hffff);
        wait_drained();

        foreach (phase_seeds[i])
        begin
            write_seed(phase_seeds[i]);
            run_random_phase(225);
            wait_drained();
        end

        $display("covered %0d input words over 5 seed settings with random idling",
                 items_sent);
        $display("%0d hashes compared, %0d of them flagged a length mismatch",
                 hashes_checked, mismatches_flagged);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
src/mlh_pkg.sv
src/mlh_front.sv
src/mlh_op_queue.sv
src/mlh_back.sv
src/murmur2_lowercase_hash_unit.sv
test/mlh_checker.sv
test/murmur2_lowercase_hash_unit_tb.sv
